// File: src/domain_name_syntax_check_unit_macros.svh
// Assertion macros shared by the host name checker.
`ifndef DOMAIN_NAME_SYNTAX_CHECK_UNIT_MACROS_SVH
`define DOMAIN_NAME_SYNTAX_CHECK_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DNSC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("host name checker assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DNSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("host name checker assertion failed");

`endif

// File: src/dnsc_pkg.sv
package dnsc_pkg;

    // Limits on name and label length.
    localparam logic [7:0] NAME_MIN  = 8'd4;
    localparam logic [7:0] NAME_MAX  = 8'd253;
    localparam logic [6:0] LABEL_MAX = 7'd63;

    // Characters with a special role.
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

    // Status codes on the result channel.
    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_BAD_PORT     = 3'd1;
    localparam logic [2:0] STATUS_BAD_LENGTH   = 3'd2;
    localparam logic [2:0] STATUS_BAD_CHAR     = 3'd3;
    localparam logic [2:0] STATUS_DOT_AT_END   = 3'd4;
    localparam logic [2:0] STATUS_NO_DOT       = 3'd5;
    localparam logic [2:0] STATUS_LABEL_LENGTH = 3'd6;
    localparam logic [2:0] STATUS_LABEL_HYPHEN = 3'd7;

    // Codes of the first label error.
    localparam logic [1:0] LERR_NONE   = 2'd0;
    localparam logic [1:0] LERR_LENGTH = 2'd1;
    localparam logic [1:0] LERR_HYPHEN = 2'd2;

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0]  character;
        logic        last;
        logic [15:0] port;
    } byte_word_t;

    // Input register contents handed to the scan logic.
    typedef struct packed {
        logic       valid;
        byte_word_t word;
    } stage_t;

    // Result handed from the scan logic to the output register.
    typedef struct packed {
        logic       valid;
        logic [2:0] status;
    } result_t;

    // True for letters, digits, dot and hyphen.
    function automatic logic allowed_byte(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CHAR_DOT, CHAR_HYPHEN};
    endfunction

    // Judges one finished label.
    function automatic logic [1:0] judge_label(input logic [6:0] len,
                                               input logic       starts_h,
                                               input logic       ends_h);
        logic [1:0] code;
        if (len == 7'd0 || len > LABEL_MAX) begin
            code = LERR_LENGTH;
        end
        else if (starts_h || ends_h) begin
            code = LERR_HYPHEN;
        end
        else begin
            code = LERR_NONE;
        end
        return code;
    endfunction

endpackage

// File: src/dnsc_if.sv
// Byte channel: one byte of the host name per word.
interface dnsc_byte_if;
    logic        valid;
    logic        ready;
    logic [7:0]  character;
    logic        last;
    logic [15:0] port;

    modport source (output valid, output character, output last, output port, input ready);
    modport sink (input valid, input character, input last, input port, output ready);
endinterface

// Result channel: one status word per name.
interface dnsc_status_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;

    modport source (output valid, output status, input ready);
    modport sink (input valid, input status, output ready);
endinterface

// File: src/dnsc_in_stage.sv
module dnsc_in_stage (
    input  logic                clk,
    input  logic                rst_n,
    dnsc_byte_if.sink           bytes,
    input  logic                advance,
    output dnsc_pkg::stage_t    stage
);
    import dnsc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    byte_word_t word_reg;
    logic       accept;

    // The register takes a new word when empty or when its word moves on.
    assign bytes.ready = !valid_reg || advance;
    assign accept      = bytes.valid && bytes.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.character <= bytes.character;
            word_reg.last      <= bytes.last;
            word_reg.port      <= bytes.port;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.word  = word_reg;

endmodule

// File: src/dnsc_scan.sv
`include "domain_name_syntax_check_unit_macros.svh"

module dnsc_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  dnsc_pkg::stage_t    stage,
    input  logic                out_free,
    output logic                advance,
    output dnsc_pkg::result_t   result
);
    import dnsc_pkg::*;

    logic [7:0] name_length_reg, name_length_next;
    logic       bad_character_seen_reg, bad_character_seen_next;
    logic       first_byte_is_dot_reg, first_byte_is_dot_next;
    logic [7:0] previous_byte_reg, previous_byte_next;
    logic       dot_seen_reg, dot_seen_next;
    logic [6:0] label_length_reg, label_length_next;
    logic       label_starts_hyphen_reg, label_starts_hyphen_next;
    logic [1:0] first_label_error_reg, first_label_error_next;

    logic [7:0] c;
    logic       is_dot;
    logic       is_hyphen;
    logic       first;
    logic [7:0] len;
    logic [6:0] label_inc;
    logic       bad;
    logic       fdot;
    logic       any_dot;
    logic [1:0] lerr_dot;
    logic [1:0] lerr_final;
    logic [2:0] status;

    // A last byte waits until the output register is free.
    assign advance = stage.valid && (!stage.word.last || out_free);

    // Per-byte values.
    assign c         = stage.word.character;
    assign is_dot    = (c == CHAR_DOT);
    assign is_hyphen = (c == CHAR_HYPHEN);
    assign first     = (name_length_reg == 8'd0);
    assign len       = (name_length_reg == 8'hFF) ? 8'hFF : name_length_reg + 8'd1;
    assign label_inc = (label_length_reg == 7'h7F) ? 7'h7F : label_length_reg + 7'd1;
    assign bad       = bad_character_seen_reg || !allowed_byte(c);
    assign fdot      = first ? is_dot : first_byte_is_dot_reg;
    assign any_dot   = dot_seen_reg || is_dot;

    // Label verdict when a dot closes the label.
    always_comb
    begin
        if (first_label_error_reg == LERR_NONE)
        begin
            lerr_dot = judge_label(label_length_reg, label_starts_hyphen_reg,
                                   label_length_reg != 7'd0 &&
                                   previous_byte_reg == CHAR_HYPHEN);
        end
        else
        begin
            lerr_dot = first_label_error_reg;
        end
    end

    // Label verdict when the last byte closes the final label.
    always_comb
    begin
        if (!is_dot && first_label_error_reg == LERR_NONE)
        begin
            lerr_final = judge_label(label_inc,
                                     (label_length_reg == 7'd0) ? is_hyphen
                                                                : label_starts_hyphen_reg,
                                     is_hyphen);
        end
        else
        begin
            lerr_final = first_label_error_reg;
        end
    end

    // Status in check order.
    always_comb
    begin
        if (stage.word.port == 16'd0)
        begin
            status = STATUS_BAD_PORT;
        end
        else if (len > NAME_MAX || len < NAME_MIN)
        begin
            status = STATUS_BAD_LENGTH;
        end
        else if (bad)
        begin
            status = STATUS_BAD_CHAR;
        end
        else if (fdot || is_dot)
        begin
            status = STATUS_DOT_AT_END;
        end
        else if (!any_dot)
        begin
            status = STATUS_NO_DOT;
        end
        else if (lerr_final == LERR_LENGTH)
        begin
            status = STATUS_LABEL_LENGTH;
        end
        else if (lerr_final == LERR_HYPHEN)
        begin
            status = STATUS_LABEL_HYPHEN;
        end
        else
        begin
            status = STATUS_OK;
        end
    end

    assign result.valid  = advance && stage.word.last;
    assign result.status = status;

    // State update: the last byte clears everything for the next name.
    always_comb
    begin
        name_length_next         = name_length_reg;
        bad_character_seen_next  = bad_character_seen_reg;
        first_byte_is_dot_next   = first_byte_is_dot_reg;
        previous_byte_next       = previous_byte_reg;
        dot_seen_next            = dot_seen_reg;
        label_length_next        = label_length_reg;
        label_starts_hyphen_next = label_starts_hyphen_reg;
        first_label_error_next   = first_label_error_reg;
        if (advance)
        begin
            if (stage.word.last)
            begin
                name_length_next         = 8'd0;
                bad_character_seen_next  = 1'b0;
                first_byte_is_dot_next   = 1'b0;
                previous_byte_next       = 8'd0;
                dot_seen_next            = 1'b0;
                label_length_next        = 7'd0;
                label_starts_hyphen_next = 1'b0;
                first_label_error_next   = LERR_NONE;
            end
            else
            begin
                name_length_next        = len;
                bad_character_seen_next = bad;
                first_byte_is_dot_next  = fdot;
                previous_byte_next      = c;
                dot_seen_next           = any_dot;
                if (is_dot)
                begin
                    first_label_error_next   = lerr_dot;
                    label_length_next        = 7'd0;
                    label_starts_hyphen_next = 1'b0;
                end
                else
                begin
                    if (label_length_reg == 7'd0)
                    begin
                        label_starts_hyphen_next = is_hyphen;
                    end
                    label_length_next = label_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            name_length_reg         <= 8'd0;
            bad_character_seen_reg  <= 1'b0;
            first_byte_is_dot_reg   <= 1'b0;
            previous_byte_reg       <= 8'd0;
            dot_seen_reg            <= 1'b0;
            label_length_reg        <= 7'd0;
            label_starts_hyphen_reg <= 1'b0;
            first_label_error_reg   <= LERR_NONE;
        end
        else
        begin
            name_length_reg         <= name_length_next;
            bad_character_seen_reg  <= bad_character_seen_next;
            first_byte_is_dot_reg   <= first_byte_is_dot_next;
            previous_byte_reg       <= previous_byte_next;
            dot_seen_reg            <= dot_seen_next;
            label_length_reg        <= label_length_next;
            label_starts_hyphen_reg <= label_starts_hyphen_next;
            first_label_error_reg   <= first_label_error_next;
        end
    end

    // A finished name leaves the counters cleared.
    `DNSC_ASSERT_NEXT(a_clear_after_last, clk, rst_n, advance && stage.word.last, name_length_reg == 8'd0 && label_length_reg == 7'd0)
    // A label cannot hold bytes while the name holds none.
    `DNSC_ASSERT_SAME(a_label_within_name, clk, rst_n, name_length_reg == 8'd0, label_length_reg == 7'd0)
    // Before any dot, in a name under 127 bytes, the one label spans the whole name.
    `DNSC_ASSERT_SAME(a_single_label, clk, rst_n, !dot_seen_reg && name_length_reg < 8'd127, label_length_reg == name_length_reg[6:0])
    // A result is only given when a word moves on.
    `DNSC_ASSERT_SAME(a_result_needs_room, clk, rst_n, result.valid, out_free && stage.valid)

endmodule

// File: src/dnsc_out_stage.sv
module dnsc_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  dnsc_pkg::result_t   result_in,
    output logic                out_free,
    dnsc_status_if.source       result
);
    import dnsc_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [2:0] status_reg;

    // Room for a new status when empty or when the held one is taken.
    assign out_free = !valid_reg || result.ready;

    always_comb
    begin
        if (result_in.valid)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_in.valid)
        begin
            status_reg <= result_in.status;
        end
    end

    assign result.valid  = valid_reg;
    assign result.status = status_reg;

endmodule

// File: src/domain_name_syntax_check_unit.sv
// Channel   Role   Word contents
// bytes     sink   character[7:0], last, port[15:0]
// result    source status[2:0], one word per name
//
// One byte is taken per cycle unless the last byte of a name waits in the
// input register for a free output register. The status is offered by the
// output register; the checks sit between it and the input register.
// Reset clears all name state and empties both registers.
// A stalled result holds the last byte of the next name in the input register;
// bytes before it keep flowing.
module domain_name_syntax_check_unit (
    input  logic          clk,
    input  logic          rst_n,
    dnsc_byte_if.sink     bytes,
    dnsc_status_if.source result
);
    import dnsc_pkg::*;

    stage_t  stage;
    result_t scan_result;
    logic    advance;
    logic    out_free;

    dnsc_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .bytes   (bytes),
        .advance (advance),
        .stage   (stage)
    );

    dnsc_scan u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .stage    (stage),
        .out_free (out_free),
        .advance  (advance),
        .result   (scan_result)
    );

    dnsc_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .result_in (scan_result),
        .out_free  (out_free),
        .result    (result)
    );

endmodule
